### design/acp_pkg.sv
// Shared types and constants for the AVC configuration record parser.
`default_nettype none
package acp_pkg;

    // Parse phase, one-hot
    typedef enum logic [14:0] {
        PH_IDLE   = 15'h0001,
        PH_VER    = 15'h0002,
        PH_PROF   = 15'h0004,
        PH_COMPAT = 15'h0008,
        PH_LEVEL  = 15'h0010,
        PH_LENSZ  = 15'h0020,
        PH_SEQCNT = 15'h0040,
        PH_SEQHI  = 15'h0080,
        PH_SEQLO  = 15'h0100,
        PH_SEQDAT = 15'h0200,
        PH_PICCNT = 15'h0400,
        PH_PICHI  = 15'h0800,
        PH_PICLO  = 15'h1000,
        PH_PICDAT = 15'h2000,
        PH_DONE   = 15'h4000
    } phase_t;

    // Byte roles
    localparam logic [3:0] ROLE_VERSION  = 4'd0;
    localparam logic [3:0] ROLE_PROFILE  = 4'd1;
    localparam logic [3:0] ROLE_COMPAT   = 4'd2;
    localparam logic [3:0] ROLE_LEVEL    = 4'd3;
    localparam logic [3:0] ROLE_LENSIZE  = 4'd4;
    localparam logic [3:0] ROLE_SEQCOUNT = 4'd5;
    localparam logic [3:0] ROLE_SEQLEN   = 4'd6;
    localparam logic [3:0] ROLE_SEQDATA  = 4'd7;
    localparam logic [3:0] ROLE_PICCOUNT = 4'd8;
    localparam logic [3:0] ROLE_PICLEN   = 4'd9;
    localparam logic [3:0] ROLE_PICDATA  = 4'd10;
    localparam logic [3:0] ROLE_IGNORED  = 4'd11;

    // Status codes
    localparam logic [1:0] STAT_BUSY    = 2'd0;
    localparam logic [1:0] STAT_SUCCESS = 2'd1;
    localparam logic [1:0] STAT_NO_DATA = 2'd2;
    localparam logic [1:0] STAT_TRAIL   = 2'd3;

    localparam logic [7:0] MIN_BODY_RESET = 8'd7;
    localparam logic [7:0] LENSZ_MASK     = 8'h03;
    localparam logic [7:0] SEQCNT_MASK    = 8'h1f;

    // Parser state carried between bytes
    typedef struct packed {
        phase_t      phase;
        logic [23:0] bytes_left;
        logic [7:0]  params_left;
        logic [15:0] payload_left;
        logic [7:0]  length_high;
        logic [7:0]  param_counter;
        logic [2:0]  nalu_size;
    } parse_state_t;

    // One result transaction
    typedef struct packed {
        logic [3:0]  byte_role;
        logic [15:0] field_value;
        logic [7:0]  param_index;
        logic [2:0]  nalu_len_bytes;
        logic [1:0]  status;
        logic        done_res;
    } result_t;

endpackage
`default_nettype wire

### design/acp_step.sv
// Combinational parse step: one body byte against the current parser state.
`default_nettype none
module acp_step (
    input  wire acp_pkg::parse_state_t st,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  start_req,
    input  wire logic [23:0]           body_size,
    input  wire logic [7:0]            min_body_size,
    output acp_pkg::parse_state_t      st_next,
    output acp_pkg::result_t           res
);

    always_comb begin
        acp_pkg::parse_state_t nx;
        logic        go;
        logic        seq;
        logic [15:0] len;
        logic [7:0]  pl_dec;
        logic [15:0] pay_dec;
        logic [3:0]  role;
        logic [15:0] val;
        logic [7:0]  idx;
        logic [1:0]  stat;
        logic        done;

        nx      = st;
        go      = 1'b1;
        seq     = 1'b0;
        len     = {st.length_high, data_byte};
        pl_dec  = st.params_left - 8'd1;
        pay_dec = st.payload_left - 16'd1;
        role    = acp_pkg::ROLE_IGNORED;
        val     = 16'd0;
        idx     = 8'd0;
        stat    = acp_pkg::STAT_BUSY;
        done    = 1'b0;

        // New body: clear state, reject undersized bodies
        if (start_req) begin
            nx.bytes_left    = body_size;
            nx.params_left   = 8'd0;
            nx.payload_left  = 16'd0;
            nx.length_high   = 8'd0;
            nx.param_counter = 8'd0;
            nx.nalu_size     = 3'd1;
            if (body_size < {16'd0, min_body_size}) begin
                nx.phase = acp_pkg::PH_DONE;
                stat     = acp_pkg::STAT_NO_DATA;
                done     = 1'b1;
                go       = 1'b0;
            end else begin
                nx.phase = acp_pkg::PH_VER;
            end
        end

        if (go) begin
            if (nx.phase == acp_pkg::PH_IDLE || nx.phase == acp_pkg::PH_DONE) begin
                // stray byte: tagged as ignored, status busy, not done
            end else if (nx.bytes_left == 24'd0 ||
                         ((nx.phase == acp_pkg::PH_SEQHI || nx.phase == acp_pkg::PH_PICHI)
                          && nx.bytes_left < 24'd2)) begin
                // ran past the end of the body
                nx.phase = acp_pkg::PH_DONE;
                stat     = acp_pkg::STAT_NO_DATA;
                done     = 1'b1;
            end else begin
                nx.bytes_left = nx.bytes_left - 24'd1;
                val           = {8'd0, data_byte};
                unique case (nx.phase) inside
                    acp_pkg::PH_VER: begin
                        role     = acp_pkg::ROLE_VERSION;
                        nx.phase = acp_pkg::PH_PROF;
                    end
                    acp_pkg::PH_PROF: begin
                        role     = acp_pkg::ROLE_PROFILE;
                        nx.phase = acp_pkg::PH_COMPAT;
                    end
                    acp_pkg::PH_COMPAT: begin
                        role     = acp_pkg::ROLE_COMPAT;
                        nx.phase = acp_pkg::PH_LEVEL;
                    end
                    acp_pkg::PH_LEVEL: begin
                        role     = acp_pkg::ROLE_LEVEL;
                        nx.phase = acp_pkg::PH_LENSZ;
                    end
                    acp_pkg::PH_LENSZ: begin
                        role         = acp_pkg::ROLE_LENSIZE;
                        nx.nalu_size = 3'd1 + {1'b0, data_byte[1:0] & LENSZ_MASK_2()};
                        nx.phase     = acp_pkg::PH_SEQCNT;
                    end
                    acp_pkg::PH_SEQCNT: begin
                        role             = acp_pkg::ROLE_SEQCOUNT;
                        nx.params_left   = data_byte & acp_pkg::SEQCNT_MASK;
                        nx.param_counter = 8'd0;
                        val              = {8'd0, nx.params_left};
                        nx.phase         = (nx.params_left == 8'd0) ? acp_pkg::PH_PICCNT
                                                                    : acp_pkg::PH_SEQHI;
                    end
                    acp_pkg::PH_PICCNT: begin
                        role             = acp_pkg::ROLE_PICCOUNT;
                        nx.params_left   = data_byte;
                        nx.param_counter = 8'd0;
                        if (data_byte == 8'd0) begin
                            nx.phase = acp_pkg::PH_DONE;
                            stat     = (nx.bytes_left == 24'd0) ? acp_pkg::STAT_SUCCESS
                                                                : acp_pkg::STAT_TRAIL;
                            done     = 1'b1;
                        end else begin
                            nx.phase = acp_pkg::PH_PICHI;
                        end
                    end
                    acp_pkg::PH_SEQHI, acp_pkg::PH_PICHI: begin
                        seq            = (nx.phase == acp_pkg::PH_SEQHI);
                        role           = seq ? acp_pkg::ROLE_SEQLEN : acp_pkg::ROLE_PICLEN;
                        nx.length_high = data_byte;
                        val            = {data_byte, 8'd0};
                        idx            = st.param_counter;
                        nx.phase       = seq ? acp_pkg::PH_SEQLO : acp_pkg::PH_PICLO;
                    end
                    acp_pkg::PH_SEQLO, acp_pkg::PH_PICLO: begin
                        seq  = (nx.phase == acp_pkg::PH_SEQLO);
                        role = seq ? acp_pkg::ROLE_SEQLEN : acp_pkg::ROLE_PICLEN;
                        val  = len;
                        idx  = st.param_counter;
                        if ({8'd0, len} > nx.bytes_left) begin
                            nx.phase = acp_pkg::PH_DONE;
                            stat     = acp_pkg::STAT_NO_DATA;
                            done     = 1'b1;
                        end else if (len == 16'd0) begin
                            // empty parameter ends at once
                            nx.params_left   = pl_dec;
                            nx.param_counter = st.param_counter + 8'd1;
                            if (pl_dec != 8'd0) begin
                                nx.phase = seq ? acp_pkg::PH_SEQHI : acp_pkg::PH_PICHI;
                            end else if (seq) begin
                                nx.phase = acp_pkg::PH_PICCNT;
                            end else begin
                                nx.phase = acp_pkg::PH_DONE;
                                stat     = (nx.bytes_left == 24'd0) ? acp_pkg::STAT_SUCCESS
                                                                    : acp_pkg::STAT_TRAIL;
                                done     = 1'b1;
                            end
                        end else begin
                            nx.payload_left = len;
                            nx.phase        = seq ? acp_pkg::PH_SEQDAT : acp_pkg::PH_PICDAT;
                        end
                    end
                    acp_pkg::PH_SEQDAT, acp_pkg::PH_PICDAT: begin
                        seq             = (nx.phase == acp_pkg::PH_SEQDAT);
                        role            = seq ? acp_pkg::ROLE_SEQDATA : acp_pkg::ROLE_PICDATA;
                        idx             = st.param_counter;
                        nx.payload_left = pay_dec;
                        if (pay_dec == 16'd0) begin
                            nx.params_left   = pl_dec;
                            nx.param_counter = st.param_counter + 8'd1;
                            if (pl_dec != 8'd0) begin
                                nx.phase = seq ? acp_pkg::PH_SEQHI : acp_pkg::PH_PICHI;
                            end else if (seq) begin
                                nx.phase = acp_pkg::PH_PICCNT;
                            end else begin
                                nx.phase = acp_pkg::PH_DONE;
                                stat     = (nx.bytes_left == 24'd0) ? acp_pkg::STAT_SUCCESS
                                                                    : acp_pkg::STAT_TRAIL;
                                done     = 1'b1;
                            end
                        end
                    end
                    default: begin
                        val = 16'd0;
                    end
                endcase
            end
        end

        st_next            = nx;
        res.byte_role      = role;
        res.field_value    = val;
        res.param_index    = idx;
        res.nalu_len_bytes = nx.nalu_size;
        res.status         = stat;
        res.done_res       = done;
    end

    // Low two bits of the length-size mask
    function automatic logic [1:0] LENSZ_MASK_2();
        LENSZ_MASK_2 = acp_pkg::LENSZ_MASK[1:0];
    endfunction

endmodule
`default_nettype wire

### design/avc_config_record_parser_top.sv
// Top level of the AVC configuration record parser: input stage, state and result register.
//
//  Channel  | Ports                                   | Direction | Moves
//  ---------+-----------------------------------------+-----------+-----------------------------
//  s_       | s_valid/s_ready, s_data_byte, s_start_  | in        | one body byte per transaction
//           | req, s_body_size                        |           |
//  m_       | m_valid/m_ready, m_byte_role, m_field_  | out       | one tagged result per byte
//           | value, m_param_index, m_nalu_len_bytes, |           |
//           | m_status, m_done_res                    |           |
//  cfg_     | cfg_we, cfg_wdata                       | in        | min_body_size write
//
//  One byte per cycle while the m_ side does not stall; a result appears on m_ once its
//  byte has passed the input register and then the result register.
//  The parse step sits between the input register and the result register.
//  Reset (aresetn low, synchronous) empties both stages, idles the parser and sets
//  min_body_size to 7. A stalled m_ side holds the result; s_ready drops only once
//  both the input register and the result register are full.
`default_nettype none
module avc_config_record_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_start_req,
    input  wire logic [23:0] s_body_size,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_byte_role,
    output logic [15:0]      m_field_value,
    output logic [7:0]       m_param_index,
    output logic [2:0]       m_nalu_len_bytes,
    output logic [1:0]       m_status,
    output logic             m_done_res
);

    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  in_start_reg;
    logic [23:0]           in_size_reg;
    logic                  out_valid_reg;
    acp_pkg::result_t      out_reg;
    acp_pkg::result_t      res_next;
    acp_pkg::parse_state_t state_reg;
    acp_pkg::parse_state_t state_next;
    logic [7:0]            min_body_size_reg;
    logic                  advance;

    // Input stage moves into the result register when that is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    acp_step u_step (
        .st            (state_reg),
        .data_byte     (in_data_reg),
        .start_req     (in_start_reg),
        .body_size     (in_size_reg),
        .min_body_size (min_body_size_reg),
        .st_next       (state_next),
        .res           (res_next)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_body_size_reg <= acp_pkg::MIN_BODY_RESET;
        end else if (cfg_we) begin
            min_body_size_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_start_reg <= s_start_req;
            in_size_reg  <= s_body_size;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= acp_pkg::PH_IDLE;
            state_reg.bytes_left    <= 24'd0;
            state_reg.params_left   <= 8'd0;
            state_reg.payload_left  <= 16'd0;
            state_reg.length_high   <= 8'd0;
            state_reg.param_counter <= 8'd0;
            state_reg.nalu_size     <= 3'd1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_byte_role      = out_reg.byte_role;
    assign m_field_value    = out_reg.field_value;
    assign m_param_index    = out_reg.param_index;
    assign m_nalu_len_bytes = out_reg.nalu_len_bytes;
    assign m_status         = out_reg.status;
    assign m_done_res       = out_reg.done_res;

endmodule
`default_nettype wire

### verif/avc_config_record_parser_top_test.sv
// Self-checking testbench for the AVC configuration record parser: directed records, then random ones.
`timescale 1ns / 100ps
module avc_config_record_parser_top_test;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_start_req;
    logic [23:0] s_body_size;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_byte_role;
    logic [15:0] m_field_value;
    logic [7:0]  m_param_index;
    logic [2:0]  m_nalu_len_bytes;
    logic [1:0]  m_status;
    logic        m_done_res;

    // One row of the directed table; 'typed' rows carry their own expected result
    typedef struct {
        logic [7:0]       data;
        logic             start;
        logic [23:0]      size;
        logic             typed;
        acp_pkg::result_t want;
    } dir_row_t;

    localparam acp_pkg::result_t NO_RES = '0;

    // Parser model state
    acp_pkg::phase_t pr_phase;
    logic [23:0]     pr_bytes_left;
    logic [7:0]      pr_params_left;
    logic [15:0]     pr_payload_left;
    logic [7:0]      pr_len_high;
    logic [7:0]      pr_param_idx;
    logic [2:0]      pr_nalu;
    logic [7:0]      pr_min_body;

    acp_pkg::result_t tagged_q[$];
    dir_row_t         dir_rows[$];
    logic [7:0]       rec_bytes[$];
    logic [23:0]      rec_size;
    int               n_sent;
    int               n_parsed;
    int               n_results;
    int               n_fail;
    int               cycle_cnt;

    avc_config_record_parser_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_start_req      (s_start_req),
        .s_body_size      (s_body_size),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_role      (m_byte_role),
        .m_field_value    (m_field_value),
        .m_param_index    (m_param_index),
        .m_nalu_len_bytes (m_nalu_len_bytes),
        .m_status         (m_status),
        .m_done_res       (m_done_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Queue helpers
    function automatic void exp_append(input acp_pkg::result_t r);
        tagged_q = {tagged_q, r};
    endfunction

    function automatic void row_append(input dir_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void rec_append(input logic [7:0] b);
        rec_bytes = {rec_bytes, b};
    endfunction

    // A parameter's last byte: next parameter, picture count, or end of body
    function automatic void close_param(input logic seq, inout acp_pkg::result_t r);
        pr_params_left = pr_params_left - 8'd1;
        pr_param_idx   = pr_param_idx + 8'd1;
        if (pr_params_left != 8'd0) begin
            pr_phase = seq ? acp_pkg::PH_SEQHI : acp_pkg::PH_PICHI;
        end else if (seq) begin
            pr_phase = acp_pkg::PH_PICCNT;
        end else begin
            pr_phase   = acp_pkg::PH_DONE;
            r.status   = (pr_bytes_left == 24'd0) ? acp_pkg::STAT_SUCCESS
                                                  : acp_pkg::STAT_TRAIL;
            r.done_res = 1'b1;
        end
    endfunction

    // Tag one body byte and advance the parser model
    function automatic acp_pkg::result_t parse_byte(input logic [7:0] b, input logic st,
                                                    input logic [23:0] size);
        acp_pkg::result_t r;
        logic             seq;
        logic             too_small;
        logic [15:0]      len;
        r           = '0;
        r.byte_role = acp_pkg::ROLE_IGNORED;
        too_small   = st && (size < {16'd0, pr_min_body});
        if (st) begin
            pr_bytes_left   = size;
            pr_params_left  = '0;
            pr_payload_left = '0;
            pr_len_high     = '0;
            pr_param_idx    = '0;
            pr_nalu         = 3'd1;
            pr_phase        = too_small ? acp_pkg::PH_DONE : acp_pkg::PH_VER;
        end
        if (too_small) begin
            r.status   = acp_pkg::STAT_NO_DATA;
            r.done_res = 1'b1;
        end else if (pr_phase != acp_pkg::PH_IDLE && pr_phase != acp_pkg::PH_DONE) begin
            if (pr_bytes_left == 24'd0 ||
                ((pr_phase == acp_pkg::PH_SEQHI || pr_phase == acp_pkg::PH_PICHI) &&
                 pr_bytes_left < 24'd2)) begin
                // structural byte with the body already used up
                pr_phase   = acp_pkg::PH_DONE;
                r.status   = acp_pkg::STAT_NO_DATA;
                r.done_res = 1'b1;
            end else begin
                pr_bytes_left = pr_bytes_left - 24'd1;
                case (pr_phase) inside
                    acp_pkg::PH_VER: begin
                        r.byte_role   = acp_pkg::ROLE_VERSION;
                        r.field_value = {8'd0, b};
                        pr_phase      = acp_pkg::PH_PROF;
                    end
                    acp_pkg::PH_PROF: begin
                        r.byte_role   = acp_pkg::ROLE_PROFILE;
                        r.field_value = {8'd0, b};
                        pr_phase      = acp_pkg::PH_COMPAT;
                    end
                    acp_pkg::PH_COMPAT: begin
                        r.byte_role   = acp_pkg::ROLE_COMPAT;
                        r.field_value = {8'd0, b};
                        pr_phase      = acp_pkg::PH_LEVEL;
                    end
                    acp_pkg::PH_LEVEL: begin
                        r.byte_role   = acp_pkg::ROLE_LEVEL;
                        r.field_value = {8'd0, b};
                        pr_phase      = acp_pkg::PH_LENSZ;
                    end
                    acp_pkg::PH_LENSZ: begin
                        pr_nalu       = 3'd1 + {1'b0, b[1:0]};
                        r.byte_role   = acp_pkg::ROLE_LENSIZE;
                        r.field_value = {8'd0, b};
                        pr_phase      = acp_pkg::PH_SEQCNT;
                    end
                    acp_pkg::PH_SEQCNT: begin
                        pr_params_left = b & acp_pkg::SEQCNT_MASK;
                        pr_param_idx   = '0;
                        r.byte_role    = acp_pkg::ROLE_SEQCOUNT;
                        r.field_value  = {8'd0, pr_params_left};
                        pr_phase       = (pr_params_left == 8'd0) ? acp_pkg::PH_PICCNT
                                                                  : acp_pkg::PH_SEQHI;
                    end
                    acp_pkg::PH_PICCNT: begin
                        pr_params_left = b;
                        pr_param_idx   = '0;
                        r.byte_role    = acp_pkg::ROLE_PICCOUNT;
                        r.field_value  = {8'd0, b};
                        if (b == 8'd0) begin
                            pr_phase   = acp_pkg::PH_DONE;
                            r.status   = (pr_bytes_left == 24'd0) ? acp_pkg::STAT_SUCCESS
                                                                  : acp_pkg::STAT_TRAIL;
                            r.done_res = 1'b1;
                        end else begin
                            pr_phase = acp_pkg::PH_PICHI;
                        end
                    end
                    acp_pkg::PH_SEQHI, acp_pkg::PH_PICHI: begin
                        seq           = (pr_phase == acp_pkg::PH_SEQHI);
                        pr_len_high   = b;
                        r.byte_role   = seq ? acp_pkg::ROLE_SEQLEN : acp_pkg::ROLE_PICLEN;
                        r.field_value = {b, 8'd0};
                        r.param_index = pr_param_idx;
                        pr_phase      = seq ? acp_pkg::PH_SEQLO : acp_pkg::PH_PICLO;
                    end
                    acp_pkg::PH_SEQLO, acp_pkg::PH_PICLO: begin
                        seq           = (pr_phase == acp_pkg::PH_SEQLO);
                        len           = {pr_len_high, b};
                        r.byte_role   = seq ? acp_pkg::ROLE_SEQLEN : acp_pkg::ROLE_PICLEN;
                        r.field_value = len;
                        r.param_index = pr_param_idx;
                        if ({8'd0, len} > pr_bytes_left) begin
                            pr_phase   = acp_pkg::PH_DONE;
                            r.status   = acp_pkg::STAT_NO_DATA;
                            r.done_res = 1'b1;
                        end else if (len == 16'd0) begin
                            close_param(seq, r);
                        end else begin
                            pr_payload_left = len;
                            pr_phase        = seq ? acp_pkg::PH_SEQDAT : acp_pkg::PH_PICDAT;
                        end
                    end
                    acp_pkg::PH_SEQDAT, acp_pkg::PH_PICDAT: begin
                        seq             = (pr_phase == acp_pkg::PH_SEQDAT);
                        pr_payload_left = pr_payload_left - 16'd1;
                        r.byte_role     = seq ? acp_pkg::ROLE_SEQDATA : acp_pkg::ROLE_PICDATA;
                        r.field_value   = {8'd0, b};
                        r.param_index   = pr_param_idx;
                        if (pr_payload_left == 16'd0)
                            close_param(seq, r);
                    end
                    default: ;
                endcase
            end
        end
        r.nalu_len_bytes = pr_nalu;
        return r;
    endfunction

    // Offer one byte after a random gap; expectation is recorded on acceptance.
    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic [23:0] size,
                             input logic typed, input acp_pkg::result_t want);
        int               gap;
        acp_pkg::result_t got;
        gap = (((n_sent / 80) % 3) == 1) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_start_req <= st;
        s_body_size <= size;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = parse_byte(b, st, size);
        exp_append(typed ? want : got);
        if (!(got.byte_role == acp_pkg::ROLE_IGNORED && !got.done_res))
            n_parsed++;
        n_sent++;
        @(negedge aclk);
    endtask

    // Wait for every outstanding result, plus a few cycles for the pipeline
    task automatic drain();
        s_valid <= 1'b0;
        while (tagged_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Length-prefixed parameter with random payload; rarely a long one
    task automatic add_param();
        int len;
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 6);
        rec_append(8'(len >> 8));
        rec_append(8'(len));
        repeat (len) rec_append(8'($urandom));
    endtask

    // Well-formed record with random content, then a declared size that is exact,
    // long (trailing data), short (runs out) or a record cut off by the next start
    task automatic gen_record();
        int n_seq;
        int n_pic;
        int cut;
        rec_bytes.delete();
        repeat (5) rec_append(8'($urandom));
        n_seq = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        rec_append({3'($urandom), 5'(n_seq)});
        repeat (n_seq) add_param();
        n_pic = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
        rec_append(8'(n_pic));
        repeat (n_pic) add_param();
        rec_size = 24'(rec_bytes.size());
        case ($urandom_range(0, 9)) inside
            5, 6: rec_size = rec_size + 24'($urandom_range(1, 3));
            7:    rec_size = rec_size + 24'($urandom_range(0, 24'hFFFFFF - rec_size));
            8:    rec_size = rec_size - 24'($urandom_range(1, 4));
            9: begin
                cut = $urandom_range(1, rec_bytes.size() - 1);
                while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
            end
            default: ;
        endcase
        // mostly keep bodies above the minimum so a high minimum still parses
        if (rec_size < {16'd0, pr_min_body} && $urandom_range(0, 3) != 0)
            rec_size = {16'd0, pr_min_body} + 24'($urandom_range(0, 2));
    endtask

    // Result side: random stalls, one long hold-off, field-by-field check
    initial begin
        int               stall;
        bit               held;
        acp_pkg::result_t exp_r;
        m_ready = 1'b0;
        held    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = (((n_results / 90) % 3) == 2) ? 0 : $urandom_range(0, 19);
            if (!held && n_results >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            n_results++;
            if (tagged_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_fail++;
            end else begin
                exp_r = tagged_q.pop_front();
                if (m_byte_role !== exp_r.byte_role) begin
                    $error("byte_role: expected %0d, actual %0d", exp_r.byte_role, m_byte_role);
                    n_fail++;
                end
                if (m_field_value !== exp_r.field_value) begin
                    $error("field_value: expected %0h, actual %0h",
                           exp_r.field_value, m_field_value);
                    n_fail++;
                end
                if (m_param_index !== exp_r.param_index) begin
                    $error("param_index: expected %0d, actual %0d",
                           exp_r.param_index, m_param_index);
                    n_fail++;
                end
                if (m_nalu_len_bytes !== exp_r.nalu_len_bytes) begin
                    $error("nalu_len_bytes: expected %0d, actual %0d",
                           exp_r.nalu_len_bytes, m_nalu_len_bytes);
                    n_fail++;
                end
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_status);
                    n_fail++;
                end
                if (m_done_res !== exp_r.done_res) begin
                    $error("done_res: expected %0d, actual %0d", exp_r.done_res, m_done_res);
                    n_fail++;
                end
            end
        end
    end

    // Stimulus and sequencing
    initial begin
        logic [7:0] min_val;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_start_req = 1'b0;
        s_body_size = '0;
        n_sent      = 0;
        n_parsed    = 0;
        n_results   = 0;
        n_fail      = 0;
        pr_phase        = acp_pkg::PH_IDLE;
        pr_bytes_left   = '0;
        pr_params_left  = '0;
        pr_payload_left = '0;
        pr_len_high     = '0;
        pr_param_idx    = '0;
        pr_nalu         = 3'd1;
        pr_min_body     = acp_pkg::MIN_BODY_RESET;

        // idle, too small, byte after completion
        row_append('{8'hFF, 1'b0, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_IGNORED, 16'd0, 8'd0, 3'd1, acp_pkg::STAT_BUSY, 1'b0}});
        row_append('{8'h00, 1'b1, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_IGNORED, 16'd0, 8'd0, 3'd1, acp_pkg::STAT_NO_DATA, 1'b1}});
        row_append('{8'h5A, 1'b0, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_IGNORED, 16'd0, 8'd0, 3'd1, acp_pkg::STAT_BUSY, 1'b0}});
        // largest body, abandoned by the restart below
        row_append('{8'h00, 1'b1, 24'hFFFFFF, 1'b0, NO_RES});
        // minimal body: no parameters, ends exactly on the picture count
        row_append('{8'h01, 1'b1, 24'd7, 1'b0, NO_RES});
        row_append('{8'hFF, 1'b0, 24'hFFFFFF, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'hFF, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'hFF, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'hE0, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_PICCOUNT, 16'd0, 8'd0, 3'd4, acp_pkg::STAT_SUCCESS, 1'b1}});
        // one empty sequence parameter, then the picture count is missing
        row_append('{8'h01, 1'b1, 24'd8, 1'b0, NO_RES});
        row_append('{8'h42, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'hC0, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h1E, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'hFC, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h01, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h55, 1'b0, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_IGNORED, 16'd0, 8'd0, 3'd1, acp_pkg::STAT_NO_DATA, 1'b1}});
        // parameter length running past the end of the body
        row_append('{8'h01, 1'b1, 24'd10, 1'b0, NO_RES});
        row_append('{8'h64, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h28, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h03, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h1F, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h01, 1'b0, 24'd0, 1'b0, NO_RES});
        row_append('{8'h00, 1'b0, 24'd0, 1'b1,
                     '{acp_pkg::ROLE_SEQLEN, 16'h0100, 8'd0, 3'd4, acp_pkg::STAT_NO_DATA, 1'b1}});

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].size,
                      dir_rows[i].typed, dir_rows[i].want);

        // Random records under several minimum body sizes
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0:       min_val = 8'd0;
                1:       min_val = 8'd255;
                2:       min_val = 8'($urandom);
                default: min_val = acp_pkg::MIN_BODY_RESET;
            endcase
            cfg_we    <= 1'b1;
            cfg_wdata <= min_val;
            @(negedge aclk);
            cfg_we      <= 1'b0;
            pr_min_body = min_val;
            n_parsed    = 0;
            while (n_parsed < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise: stray bytes, now and then a stray start
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), ($urandom_range(0, 3) == 0),
                                  $urandom_range(0, 1) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 12)),
                                  1'b0, NO_RES);
                end else begin
                    gen_record();
                    foreach (rec_bytes[i])
                        send_byte(rec_bytes[i], (i == 0), (i == 0) ? rec_size : 24'($urandom),
                                  1'b0, NO_RES);
                end
            end
        end

        drain();
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
